FILE: rtl/vbs_pkg.sv
// package: shared types, constants and helpers of the vibration burst sequencer
`default_nettype none

package vbs_pkg;

  // pattern queue geometry
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int unsigned MS_W     = 16;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned RES_W    = 5;
  localparam int unsigned WAIT_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // full-scale resolution limits
  localparam logic [RES_W-1:0] RES_MIN = RES_W'(1);
  localparam logic [RES_W-1:0] RES_MAX = RES_W'(LEVEL_W);

  typedef enum logic {
    FUNC_ENQUEUE = 1'b0,
    FUNC_TICK    = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INTENSITY = 2'd0,
    CFG_PWM_RES_BITS  = 2'd1,
    CFG_GAP_MS        = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ON   = 4'b0010,
    PH_OFF  = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [MS_W-1:0]    period_count;
    logic [MS_W-1:0]    on_ms;
    logic [MS_W-1:0]    off_ms;
  } pattern_t;

  typedef struct packed {
    logic               func;
    logic [MS_W-1:0]    off_ms;
    logic [MS_W-1:0]    on_ms;
    logic [MS_W-1:0]    period_count;
    logic [LEVEL_W-1:0] level;
    logic               full_scale;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive_level;
    logic               busy_res;
    logic [WAIT_W-1:0]  waiting;
    logic               dropped;
  } result_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] min_intensity;
    logic [RES_W-1:0]   res_bits;
    logic [MS_W-1:0]    gap_ms;
  } cfg_t;

  // queue request from the sequencer
  typedef struct packed {
    logic             push;
    pattern_t         push_pat;
    logic             push_empty;
    logic [CNT_W-1:0] pop_n;
  } fifo_op_t;

  // queue view toward the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             found;
    logic [PTR_W-1:0] skip;
    pattern_t         pat;
  } fifo_look_t;

  // a pattern that ends as soon as it starts
  function automatic logic pat_is_empty(pattern_t p);
    return (p.period_count == '0) || ((p.on_ms == '0) && (p.off_ms == '0));
  endfunction

  // ring index wrap, sum stays below twice the depth
  function automatic logic [PTR_W-1:0] wrap_idx(logic [PTR_W:0] s);
    logic [PTR_W:0] r;
    r = (s >= (PTR_W+1)'(QUEUE_DEPTH)) ? s - (PTR_W+1)'(QUEUE_DEPTH) : s;
    return r[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vbs_if.sv
// interfaces: input item channel and result item channel
`default_nettype none

interface vbs_in_if;
  import vbs_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [MS_W-1:0]    off_ms;
  logic [MS_W-1:0]    on_ms;
  logic [MS_W-1:0]    period_count;
  logic [LEVEL_W-1:0] level;
  logic               full_scale;

  modport source (output valid, func, off_ms, on_ms, period_count, level, full_scale,
                  input ready);
  modport sink   (input valid, func, off_ms, on_ms, period_count, level, full_scale,
                  output ready);
endinterface

interface vbs_out_if;
  import vbs_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] drive_level;
  logic               busy_res;
  logic [WAIT_W-1:0]  waiting;
  logic               dropped;

  modport source (output valid, drive_level, busy_res, waiting, dropped, input ready);
  modport sink   (input valid, drive_level, busy_res, waiting, dropped, output ready);
endinterface

`default_nettype wire

FILE: rtl/vbs_fifo.sv
// pattern queue: ring storage, empty flags and leading-empty scan
`default_nettype none

module vbs_fifo import vbs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       scan_i,
  input  wire fifo_op_t   op_i,
  output      fifo_look_t look_o
);

  pattern_t         mem_q [QUEUE_DEPTH];
  logic             empty_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] wr_idx;
  logic [PTR_W-1:0] rd_idx;
  logic             found;
  logic [PTR_W-1:0] skip;

  assign wr_idx = wrap_idx((PTR_W+1)'(head_q) + (PTR_W+1)'(count_q));

  // first non-empty entry from the head, or the head when not scanning
  always_comb begin
    found = 1'b0;
    skip  = '0;
    if (!scan_i) begin
      found = (count_q != '0);
    end else begin
      for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
        if ((CNT_W'(k) < count_q) &&
            !empty_q[wrap_idx((PTR_W+1)'(head_q) + (PTR_W+1)'(k))]) begin
          found = 1'b1;
          skip  = PTR_W'(k);
        end
      end
    end
  end

  assign rd_idx = wrap_idx((PTR_W+1)'(head_q) + (PTR_W+1)'(skip));

  assign look_o.count = count_q;
  assign look_o.found = found;
  assign look_o.skip  = skip;
  assign look_o.pat   = mem_q[rd_idx];

  always_comb begin
    head_d  = wrap_idx((PTR_W+1)'(head_q) + (PTR_W+1)'(op_i.pop_n));
    count_d = count_q + CNT_W'(op_i.push) - op_i.pop_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (en_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && op_i.push) begin
      mem_q[wr_idx]   <= op_i.push_pat;
      empty_q[wr_idx] <= op_i.push_empty;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && op_i.push) |-> (count_q < CNT_W'(QUEUE_DEPTH)) && (op_i.pop_n == '0))
    else $error("push into full queue or with pop");
  a_pop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |-> (op_i.pop_n <= count_q))
    else $error("pop beyond queue contents");
`endif

endmodule

`default_nettype wire

FILE: rtl/vbs_seq.sv
// sequencer: phase state, countdowns and per-item next-state logic
`default_nettype none

module vbs_seq import vbs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire item_t      item_i,
  input  wire cfg_t       cfg_i,
  input  wire fifo_look_t look_i,
  output      logic       scan_o,
  output      fifo_op_t   op_o,
  output      result_t    res_o
);

  phase_e           ph_q, ph_d;
  logic [MS_W-1:0]  cd_q, cd_d;
  logic [MS_W-1:0]  pl_q, pl_d;
  pattern_t         cur_q, cur_d;

  logic [RES_W-1:0]   res_c;
  logic [LEVEL_W-1:0] full_lvl;
  logic [LEVEL_W-1:0] req_lvl;
  pattern_t           enq_pat;
  pattern_t           start_pat;
  logic               start;
  logic               done;
  logic               dropped;
  logic [CNT_W-1:0]   count_next;

  assign scan_o = (cfg_i.gap_ms == '0);

  // level resolved at enqueue
  always_comb begin
    if (cfg_i.res_bits < RES_MIN) begin
      res_c = RES_MIN;
    end else if (cfg_i.res_bits > RES_MAX) begin
      res_c = RES_MAX;
    end else begin
      res_c = cfg_i.res_bits;
    end
    full_lvl = {LEVEL_W{1'b1}} >> (RES_MAX - res_c);
    req_lvl  = item_i.full_scale ? full_lvl : item_i.level;
    if (req_lvl < cfg_i.min_intensity) begin
      req_lvl = cfg_i.min_intensity;
    end
    enq_pat.level        = req_lvl;
    enq_pat.period_count = item_i.period_count;
    enq_pat.on_ms        = item_i.on_ms;
    enq_pat.off_ms       = item_i.off_ms;
  end

  always_comb begin
    ph_d      = ph_q;
    cd_d      = cd_q;
    pl_d      = pl_q;
    cur_d     = cur_q;
    start     = 1'b0;
    start_pat = cur_q;
    done      = 1'b0;
    dropped   = 1'b0;
    op_o      = '0;
    op_o.push_pat   = enq_pat;
    op_o.push_empty = pat_is_empty(enq_pat);

    if (item_i.func == FUNC_ENQUEUE) begin
      if (ph_q == PH_IDLE) begin
        start     = 1'b1;
        start_pat = enq_pat;
        cur_d     = enq_pat;
      end else if (look_i.count < CNT_W'(QUEUE_DEPTH)) begin
        op_o.push = 1'b1;
      end else begin
        dropped = 1'b1;
      end
    end else if (ph_q != PH_IDLE) begin
      if (cd_q > MS_W'(1)) begin
        cd_d = cd_q - MS_W'(1);
      end else begin
        // phase ends on this tick
        unique case (ph_q)
          PH_ON: begin
            if (cur_q.off_ms != '0) begin
              ph_d = PH_OFF;
              cd_d = cur_q.off_ms;
            end else if (pl_q != MS_W'(1)) begin
              pl_d = pl_q - MS_W'(1);
              ph_d = PH_ON;
              cd_d = cur_q.on_ms;
            end else begin
              done = 1'b1;
            end
          end
          PH_OFF: begin
            if (pl_q == MS_W'(1)) begin
              done = 1'b1;
            end else begin
              pl_d = pl_q - MS_W'(1);
              ph_d = (cur_q.on_ms != '0) ? PH_ON : PH_OFF;
              cd_d = (cur_q.on_ms != '0) ? cur_q.on_ms : cur_q.off_ms;
            end
          end
          PH_GAP: begin
            start = 1'b1;
          end
          default: begin
            ph_d = PH_IDLE;
          end
        endcase
      end
    end

    if (start) begin
      if (pat_is_empty(start_pat)) begin
        done = 1'b1;
      end else begin
        ph_d = (start_pat.on_ms != '0) ? PH_ON : PH_OFF;
        cd_d = (start_pat.on_ms != '0) ? start_pat.on_ms : start_pat.off_ms;
        pl_d = start_pat.period_count;
      end
    end

    if (done) begin
      if (look_i.count != '0) begin
        op_o.pop_n = look_i.found ? CNT_W'(look_i.skip) + CNT_W'(1) : look_i.count;
        cur_d      = look_i.pat;
        if (cfg_i.gap_ms != '0) begin
          ph_d = PH_GAP;
          cd_d = cfg_i.gap_ms;
        end else if (look_i.found) begin
          // leading empty patterns skipped, this one is live
          ph_d = (look_i.pat.on_ms != '0) ? PH_ON : PH_OFF;
          cd_d = (look_i.pat.on_ms != '0) ? look_i.pat.on_ms : look_i.pat.off_ms;
          pl_d = look_i.pat.period_count;
        end else begin
          ph_d = PH_IDLE;
          cd_d = '0;
          pl_d = '0;
        end
      end else begin
        ph_d = PH_IDLE;
        cd_d = '0;
        pl_d = '0;
      end
    end
  end

  assign count_next = look_i.count + CNT_W'(op_o.push) - op_o.pop_n;

  always_comb begin
    res_o.drive_level = (ph_d == PH_ON) ? cur_d.level : '0;
    res_o.busy_res    = (ph_d != PH_IDLE);
    res_o.waiting     = WAIT_W'(count_next);
    res_o.dropped     = dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      cd_q  <= '0;
      pl_q  <= '0;
      cur_q <= '0;
    end else if (en_i) begin
      ph_q  <= ph_d;
      cd_q  <= cd_d;
      pl_q  <= pl_d;
      cur_q <= cur_d;
    end
  end

`ifndef SYNTHESIS
  a_busy_cd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != PH_IDLE) |-> (cd_q != '0))
    else $error("busy phase with zero countdown");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_IDLE) |-> (look_i.count == '0))
    else $error("idle with patterns queued");
  a_on_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_ON) |-> (cur_q.on_ms != '0) && (pl_q != '0))
    else $error("on phase of an empty pattern");
`endif

endmodule

`default_nettype wire

FILE: rtl/vibration_burst_sequencer.sv
// top level: handshake registers, configuration registers, queue and sequencer
//
// channel   | dir | handshake       | payload
// ----------+-----+-----------------+--------------------------------------------
// in_ch     | in  | valid / ready   | func off_ms on_ms period_count level full_scale
// out_ch    | out | valid / ready   | drive_level busy_res waiting dropped
// cfg       | in  | cfg_we_i        | cfg_idx_i cfg_data_i
//
// one result item per input item; an accepted input passes the input register, then the result register
// one item per cycle sustained while out_ch.ready stays high: the whole step is one pass of sequencer logic
// between the input register and the result register, fed by the 8-entry queue
// a stalled result holds the result register; the input register keeps filling
// until both are full, then in_ch.ready drops
// reset clears phase, countdowns, queue pointers and config (resolution to 8)
`default_nettype none

module vibration_burst_sequencer import vbs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  vbs_in_if.sink                     in_ch,
  vbs_out_if.source                  out_ch,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // input register stage
  logic       s1_valid_q;
  item_t      s1_item_q;
  // result register stage
  logic       res_valid_q;
  result_t    res_q;
  // configuration
  cfg_t       cfg_q;

  logic       advance;
  fifo_op_t   fifo_op;
  fifo_look_t fifo_look;
  logic       scan;
  result_t    step_res;

  // step happens when the input register holds an item and the result register is free or drains this cycle
  assign advance      = s1_valid_q && (!res_valid_q || out_ch.ready);
  assign in_ch.ready  = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_q.func         <= in_ch.func;
      s1_item_q.off_ms       <= in_ch.off_ms;
      s1_item_q.on_ms        <= in_ch.on_ms;
      s1_item_q.period_count <= in_ch.period_count;
      s1_item_q.level        <= in_ch.level;
      s1_item_q.full_scale   <= in_ch.full_scale;
    end
  end

  // config writes land at once, expected only with no item in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_intensity <= '0;
      cfg_q.res_bits      <= RES_W'(8);
      cfg_q.gap_ms        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_INTENSITY: cfg_q.min_intensity <= cfg_data_i[LEVEL_W-1:0];
        CFG_PWM_RES_BITS:  cfg_q.res_bits      <= cfg_data_i[RES_W-1:0];
        CFG_GAP_MS:        cfg_q.gap_ms        <= cfg_data_i[MS_W-1:0];
        default: begin
          // unmapped index, write ignored
        end
      endcase
    end
  end

  vbs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .scan_i (scan),
    .op_i   (fifo_op),
    .look_o (fifo_look)
  );

  vbs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (s1_item_q),
    .cfg_i  (cfg_q),
    .look_i (fifo_look),
    .scan_o (scan),
    .op_o   (fifo_op),
    .res_o  (step_res)
  );

  // result register, holds while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_ch.valid       = res_valid_q;
  assign out_ch.drive_level = res_q.drive_level;
  assign out_ch.busy_res    = res_q.busy_res;
  assign out_ch.waiting     = res_q.waiting;
  assign out_ch.dropped     = res_q.dropped;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_ch.ready) |-> !advance)
    else $error("result overwritten while stalled");
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ch.ready)
    else $error("input stalled with empty input register");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("step without result");
`endif

endmodule

`default_nettype wire
